[hdl/cvd_pkg.sv]
package cvd_pkg;

  // press counter holds up to timeout + span, timeout is 16 bits
  localparam int TIMEOUT_W = 16;
  localparam int CNT_W = 17;
  localparam int STUCK_SPAN = 50;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd600;

  localparam logic [2:0] CODE_IDLE   = 3'd0;
  localparam logic [2:0] CODE_C500   = 3'd1;
  localparam logic [2:0] CODE_C1000  = 3'd2;
  localparam logic [2:0] CODE_CHANGE = 3'd3;
  localparam logic [2:0] CODE_VEND   = 3'd4;

  localparam int CH_SMALL  = 0;
  localparam int CH_LARGE  = 1;
  localparam int CH_CANCEL = 2;
  localparam int CH_VEND   = 3;
  localparam int NUM_CH    = 4;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_C500   = 5'b00010,
    ST_C1000  = 5'b00100,
    ST_CHANGE = 5'b01000,
    ST_VEND   = 5'b10000
  } state_t;

  typedef struct packed {
    logic event_fire;
    logic stuck;
  } chan_status_t;

  function automatic logic [2:0] state_code(state_t s);
    logic [2:0] c;
    case (s)
      ST_IDLE:   c = CODE_IDLE;
      ST_C500:   c = CODE_C500;
      ST_C1000:  c = CODE_C1000;
      ST_CHANGE: c = CODE_CHANGE;
      ST_VEND:   c = CODE_VEND;
      default:   c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

[hdl/cvd_debounce.sv]
module cvd_debounce #(
  parameter int HISTORY_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           level,
  input  logic [cvd_pkg::TIMEOUT_W-1:0]  timeout,
  output cvd_pkg::chan_status_t          status
);
  import cvd_pkg::*;

  localparam logic [HISTORY_BITS-1:0] HIST_ONES = {HISTORY_BITS{1'b1}};
  localparam logic [HISTORY_BITS-1:0] HIST_EVENT = HISTORY_BITS'(1);

  logic [HISTORY_BITS-1:0] hist, hist_next;
  logic [CNT_W-1:0]        count, count_next;
  logic                    stuck_hit;
  logic                    in_window;
  logic [CNT_W:0]          bump, limit;

  assign in_window = count <= {1'b0, timeout};
  assign bump      = {1'b0, count} + (CNT_W+1)'(2);
  assign limit     = {2'b00, timeout} + (CNT_W+1)'(STUCK_SPAN);

  always_comb begin
    hist_next  = hist;
    count_next = count;
    stuck_hit  = 1'b0;
    if (!level) begin
      if (in_window) begin
        count_next = count + CNT_W'(1);
        hist_next  = {hist[HISTORY_BITS-2:0], 1'b0};
      end else if (bump >= limit) begin
        // stuck: rewind to just past timeout, pulse every span/2 ticks
        count_next = {1'b0, timeout} + CNT_W'(1);
        stuck_hit  = 1'b1;
      end else begin
        count_next = bump[CNT_W-1:0];
      end
    end else begin
      hist_next  = in_window ? {hist[HISTORY_BITS-2:0], 1'b1} : HIST_ONES;
      count_next = '0;
    end
  end

  assign status.event_fire = en && (hist_next == HIST_EVENT);
  assign status.stuck      = en && stuck_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist  <= HIST_ONES;
      count <= '0;
    end else if (en) begin
      hist  <= hist_next;
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_stuck_rewind: assert property (@(posedge clk) disable iff (rst)
    status.stuck |=> count == $past({1'b0, timeout}) + CNT_W'(1))
    else $error("stuck pulse without counter rewind");
  a_event_no_stuck: assert property (@(posedge clk) disable iff (rst)
    !(status.event_fire && status.stuck))
    else $error("event and stuck in same tick");
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    en && level |=> count == '0)
    else $error("press counter not cleared on release");
`endif

endmodule

[hdl/coin_vending_controller_debounced_top.sv]
// Coin vending controller with shift-register debounce.
// Input channel (in_valid/in_ready) carries one sampling tick: four active-low
// pins for small coin, large coin, cancel and vend. Output channel
// (out_valid/out_ready) carries one word per tick: the credit state after the
// tick, the seen flags, change and dispense commands and the stuck mask.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) sets press_timeout;
// it is always ready and should only be written while the block is idle.
// The result is registered: a tick accepted at one edge shows up at out_* right
// after it. Throughput is one tick per cycle unless the receiver stalls, set by
// the single result register; the credit machine updates in the cycle the tick
// is accepted, the debounce histories and press counters only in credit states.
// When the receiver stalls, the result word holds and in_ready drops only
// while that word is waiting and out_ready is low.
// Reset (rst, synchronous) returns to idle with no credit, histories all
// ones, counters zero, press_timeout 600 and no result pending.
module coin_vending_controller_debounced_top #(
  parameter int HISTORY_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cvd_pkg::TIMEOUT_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          coin_small_pin,
  input  logic                          coin_large_pin,
  input  logic                          cancel_pin,
  input  logic                          vend_pin,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    machine_state,
  output logic                          small_coin_seen,
  output logic                          large_coin_seen,
  output logic                          cancel_seen,
  output logic                          return_small,
  output logic                          return_large,
  output logic                          dispense,
  output logic [3:0]                    stuck_mask
);
  import cvd_pkg::*;

  logic [TIMEOUT_W-1:0] press_timeout;
  state_t               state, state_next;
  logic                 owe_small, owe_small_next;
  logic                 owe_large, owe_large_next;
  logic                 cancel_pending, cancel_pending_next;
  logic                 accept, sampling;
  logic [NUM_CH-1:0]    pins, ev, stuck;
  chan_status_t         status [NUM_CH];
  logic                 seen_s, seen_l, seen_c, ret_s, ret_l, disp;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign sampling  = (state == ST_IDLE) || (state == ST_C500) || (state == ST_C1000);

  assign pins[CH_SMALL]  = coin_small_pin;
  assign pins[CH_LARGE]  = coin_large_pin;
  assign pins[CH_CANCEL] = cancel_pin;
  assign pins[CH_VEND]   = vend_pin;

  for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
    cvd_debounce #(.HISTORY_BITS(HISTORY_BITS)) u_deb (
      .clk     (clk),
      .rst     (rst),
      .en      (accept && sampling),
      .level   (pins[i]),
      .timeout (press_timeout),
      .status  (status[i])
    );
    assign ev[i]    = status[i].event_fire;
    assign stuck[i] = status[i].stuck;
  end

  always_comb begin
    state_next          = state;
    owe_small_next      = owe_small;
    owe_large_next      = owe_large;
    cancel_pending_next = cancel_pending;
    seen_s = 1'b0;
    seen_l = 1'b0;
    seen_c = 1'b0;
    ret_s  = 1'b0;
    ret_l  = 1'b0;
    disp   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (ev[CH_SMALL]) begin
          seen_s = 1'b1; state_next = ST_C500;
        end else if (ev[CH_LARGE]) begin
          seen_l = 1'b1; state_next = ST_C1000;
        end
      end
      ST_C500: begin
        if (ev[CH_SMALL]) begin
          seen_s = 1'b1; state_next = ST_C1000;
        end else if (ev[CH_LARGE]) begin
          seen_l = 1'b1; state_next = ST_CHANGE; owe_small_next = 1'b1;
        end else if (ev[CH_CANCEL]) begin
          seen_c = 1'b1; state_next = ST_CHANGE;
          owe_small_next = 1'b1; cancel_pending_next = 1'b1;
        end
      end
      ST_C1000: begin
        if (ev[CH_SMALL]) begin
          seen_s = 1'b1; state_next = ST_CHANGE; owe_small_next = 1'b1;
        end else if (ev[CH_LARGE]) begin
          seen_l = 1'b1; state_next = ST_CHANGE; owe_large_next = 1'b1;
        end else if (ev[CH_CANCEL]) begin
          seen_c = 1'b1; state_next = ST_CHANGE;
          owe_large_next = 1'b1; cancel_pending_next = 1'b1;
        end else if (ev[CH_VEND]) begin
          state_next = ST_VEND;
        end
      end
      ST_CHANGE: begin
        // large change coin goes out first
        if (owe_large) begin
          ret_l = 1'b1; owe_large_next = 1'b0;
        end else if (owe_small) begin
          ret_s = 1'b1; owe_small_next = 1'b0;
        end
        if (cancel_pending) begin
          cancel_pending_next = 1'b0; state_next = ST_IDLE;
        end else begin
          state_next = ST_C1000;
        end
      end
      ST_VEND: begin
        disp       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_timeout  <= TIMEOUT_RESET;
      state          <= ST_IDLE;
      owe_small      <= 1'b0;
      owe_large      <= 1'b0;
      cancel_pending <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) press_timeout <= cfg_data;
      if (accept) begin
        state          <= state_next;
        owe_small      <= owe_small_next;
        owe_large      <= owe_large_next;
        cancel_pending <= cancel_pending_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      machine_state   <= state_code(state_next);
      small_coin_seen <= seen_s;
      large_coin_seen <= seen_l;
      cancel_seen     <= seen_c;
      return_small    <= ret_s;
      return_large    <= ret_l;
      dispense        <= disp;
      stuck_mask      <= stuck;
    end
  end

`ifndef SYNTHESIS
  a_vend_dispenses: assert property (@(posedge clk) disable iff (rst)
    accept && state == ST_VEND |=> out_valid && dispense && machine_state == CODE_IDLE)
    else $error("dispense state did not release product");
  a_one_seen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({small_coin_seen, large_coin_seen, cancel_seen}))
    else $error("more than one event acted on");
  a_one_return: assert property (@(posedge clk) disable iff (rst)
    out_valid && (return_small || return_large) |-> !(return_small && return_large)
      && (machine_state == CODE_IDLE || machine_state == CODE_C1000))
    else $error("bad change command");
  a_no_sample_busy: assert property (@(posedge clk) disable iff (rst)
    accept && !sampling |=> stuck_mask == 4'd0)
    else $error("stuck pulse outside credit states");
`endif

endmodule
